// ===== rtl/core/krt_pkg.sv =====
// krt_pkg: shared types and codes for the keyed record table
// operation and status codes, query, token and result structs
// no dependencies
package krt_pkg;

    // operation codes
    localparam logic [1:0] FN_INSERT    = 2'd0;
    localparam logic [1:0] FN_SEARCH    = 2'd1;
    localparam logic [1:0] FN_ADD_QTY   = 2'd2;
    localparam logic [1:0] FN_ADD_PRICE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // operation broadcast to every cell while a walk is open
    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] key;
        logic signed [31:0] new_qty;
        logic signed [31:0] new_price;
        logic signed [31:0] delta_amt;
    } query_t;

    // token handed from cell to cell, one hop per cycle
    typedef struct packed {
        logic               valid;
        logic               found;
        logic signed [31:0] old_qty;
        logic signed [31:0] old_price;
    } token_t;

    // result item
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] old_qty;
        logic signed [31:0] old_price;
    } result_t;

endpackage

// ===== rtl/core/krt_req_if.sv =====
// krt_req_if: request channel of the keyed record table
// valid/ready handshake with the operation fields, no dependencies
interface krt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] part_key;
    logic signed [31:0] new_quantity;
    logic signed [31:0] new_price_cents;
    logic signed [31:0] delta;

    modport source (
        output valid, func, part_key, new_quantity, new_price_cents, delta,
        input  ready
    );

    modport sink (
        input  valid, func, part_key, new_quantity, new_price_cents, delta,
        output ready
    );
endinterface

// ===== rtl/core/krt_rsp_if.sv =====
// krt_rsp_if: response channel of the keyed record table
// valid/ready handshake with status and old values, no dependencies
interface krt_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] old_quantity;
    logic signed [31:0] old_price_cents;

    modport source (
        output valid, status, old_quantity, old_price_cents,
        input  ready
    );

    modport sink (
        input  valid, status, old_quantity, old_price_cents,
        output ready
    );
endinterface

// ===== rtl/core/krt_cell.sv =====
// krt_cell: one table slot holding a key, quantity and price
// compares the passing token against its record and forwards it one hop
// depends on krt_pkg
module krt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  krt_pkg::query_t query,
    input  logic [CNT_W-1:0] count,
    input  krt_pkg::token_t tok_in,
    output krt_pkg::token_t tok_out
);
    import krt_pkg::*;

    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] qty_reg, qty_next;
    logic signed [31:0] price_reg, price_next;
    token_t             tok_reg, tok_next;
    logic               occupied;
    logic               hit;
    logic               slot_free;

    // slot is filled when it lies below the fill count
    assign occupied  = CNT_W'(INDEX) < count;
    assign slot_free = CNT_W'(INDEX) == count;
    assign hit       = tok_in.valid && occupied && (key_reg == query.key);

    // token update
    always_comb
    begin
        tok_next       = tok_in;
        tok_next.found = tok_in.found | hit;
        if (hit && (query.func != FN_INSERT))
        begin
            tok_next.old_qty   = qty_reg;
            tok_next.old_price = price_reg;
        end
    end

    // record update: insert into the first free slot, adds on a hit
    always_comb
    begin
        key_next   = key_reg;
        qty_next   = qty_reg;
        price_next = price_reg;
        if (tok_in.valid && (query.func == FN_INSERT) && slot_free && !tok_in.found)
        begin
            key_next   = query.key;
            qty_next   = query.new_qty;
            price_next = query.new_price;
        end
        else if (hit)
        begin
            case (query.func)
                FN_ADD_QTY:   qty_next   = qty_reg + query.delta_amt;
                FN_ADD_PRICE: price_next = price_reg + query.delta_amt;
                default:      ;
            endcase
        end
    end

    // record storage, no reset
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        qty_reg   <= qty_next;
        price_reg <= price_next;
    end

    // token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/krt_chain.sv =====
// krt_chain: row of table cells linked head to tail
// depends on krt_pkg and krt_cell
module krt_chain #(
    parameter int MAX_ENTRIES = 128,
    parameter int CNT_W       = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  krt_pkg::query_t  query,
    input  logic [CNT_W-1:0] count,
    input  krt_pkg::token_t  head_tok,
    output krt_pkg::token_t  tail_tok
);
    import krt_pkg::*;

    token_t link [0:MAX_ENTRIES];

    assign link[0] = head_tok;

    // one cell per slot, each feeding the next
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        krt_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .query   (query),
            .count   (count),
            .tok_in  (link[i]),
            .tok_out (link[i+1])
        );
    end

    assign tail_tok = link[MAX_ENTRIES];

endmodule

// ===== rtl/core/keyed_record_table_unit.sv =====
// keyed_record_table_unit: top level of the keyed record table
// controller, fill count and result buffering around the cell chain
// depends on krt_pkg, krt_req_if, krt_rsp_if and krt_chain
//
// Usage:
//   req carries one operation per transfer: insert, search, add to quantity
//   or add to price (delta in whole units, stored as delta * 100 cents).
//   rsp returns exactly one result per operation: status and the quantity
//   and price of the found record before the change (zero on insert or
//   when the key is absent).
//   Each slot of the table is a cell; a token walks the row one cell per
//   cycle. The token is launched from launch_reg after the request
//   transfer, and the result is registered in the output register after
//   the token leaves the tail; a new request is taken only once the walk
//   through the cell row has ended.
//   One operation is open at a time. A finished result is held in the
//   output register; a second one waits in a spare slot while the receiver
//   stalls, and req.ready stays low until that slot drains.
//   Reset empties the table (fill count zero) and clears all handshakes;
//   stored records keep no reset value.
module keyed_record_table_unit #(
    parameter int MAX_ENTRIES = 128
) (
    input  logic    clk,
    input  logic    rst_n,
    krt_req_if.sink   req,
    krt_rsp_if.source rsp
);
    import krt_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic             walking_reg, walking_next;
    logic             launch_reg, launch_next;
    logic             full_reg, full_next;
    logic [CNT_W-1:0] count_reg, count_next;
    query_t           query_reg, query_next;
    result_t          out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    result_t          pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;

    token_t           head_tok;
    token_t           tail_tok;
    logic             accept;
    logic             done;
    logic             out_take;
    logic signed [31:0] delta_x100;
    result_t          result;

    assign req.ready = !walking_reg && !pend_valid_reg;
    assign accept    = req.valid && req.ready;
    assign done      = tail_tok.valid;
    assign out_take  = out_valid_reg && rsp.ready;

    // delta * 100 as 64 + 32 + 4, wrapping at 32 bits
    assign delta_x100 = {req.delta[25:0], 6'b0} + {req.delta[26:0], 5'b0}
                      + {req.delta[29:0], 2'b0};

    // token injected at the head of the row
    always_comb
    begin
        head_tok           = '0;
        head_tok.valid     = launch_reg;
    end

    krt_chain #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .query    (query_reg),
        .count    (count_reg),
        .head_tok (head_tok),
        .tail_tok (tail_tok)
    );

    // result from the token leaving the tail
    always_comb
    begin
        result.old_qty   = tail_tok.old_qty;
        result.old_price = tail_tok.old_price;
        if (query_reg.func == FN_INSERT)
        begin
            if (full_reg)
            begin
                result.status = ST_FULL;
            end
            else if (tail_tok.found)
            begin
                result.status = ST_DUPLICATE;
            end
            else
            begin
                result.status = ST_OK;
            end
        end
        else
        begin
            result.status = tail_tok.found ? ST_OK : ST_NOT_FOUND;
        end
    end

    // controller and fill count
    always_comb
    begin
        walking_next = walking_reg;
        launch_next  = accept;
        full_next    = full_reg;
        count_next   = count_reg;
        query_next   = query_reg;
        if (accept)
        begin
            walking_next         = 1'b1;
            full_next            = count_reg == CNT_W'(MAX_ENTRIES);
            query_next.func      = req.func;
            query_next.key       = req.part_key;
            query_next.new_qty   = req.new_quantity;
            query_next.new_price = req.new_price_cents;
            query_next.delta_amt = (req.func == FN_ADD_PRICE) ? delta_x100 : req.delta;
        end
        else if (done)
        begin
            walking_next = 1'b0;
            if ((query_reg.func == FN_INSERT) && !full_reg && !tail_tok.found)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // output register with one spare slot
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (done)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                pend_next       = result;
                pend_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg    <= 1'b0;
            launch_reg     <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            walking_reg    <= walking_next;
            launch_reg     <= launch_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        full_reg  <= full_next;
        query_reg <= query_next;
        out_reg   <= out_next;
        pend_reg  <= pend_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.old_quantity    = out_reg.old_qty;
    assign rsp.old_price_cents = out_reg.old_price;

`ifndef SYNTH
    // a token only leaves the row while a walk is open
    a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> walking_reg)
        else $error("token left the cell row with no open walk");

    // the spare slot fills only behind a held result
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("spare result slot filled while output register empty");

    // fill count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond table size");

    // the count moves only at the end of a walk
    a_count_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        !done |=> $stable(count_reg))
        else $error("fill count changed outside the end of a walk");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for keyed_record_table_unit
// depends on krt_pkg, krt_req_if, krt_rsp_if and keyed_record_table_unit
module testbench;
    import krt_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int RANDOM_OPS  = 750;
    localparam int PHASE_LEN   = 60;

    typedef struct {
        logic [1:0]  fn;
        logic [31:0] key;
        logic [31:0] qty;
        logic [31:0] price;
        logic [31:0] dlt;
        int          phase;
    } table_op_t;

    logic clk = 1'b0;
    logic rst_n;

    krt_req_if req_ch ();
    krt_rsp_if rsp_ch ();

    keyed_record_table_unit #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the record table
    logic [31:0] shadow_key   [TABLE_DEPTH];
    logic [31:0] shadow_qty   [TABLE_DEPTH];
    logic [31:0] shadow_price [TABLE_DEPTH];
    int          shadow_fill = 0;

    table_op_t   op_queue      [$];
    result_t     results_due   [$];
    logic [31:0] inserted_keys [$];
    int          ops_queued    = 0;
    int          ops_accepted  = 0;
    int          ops_answered  = 0;
    int          error_count   = 0;
    int          status_seen   [4] = '{default: 0};
    int          cur_phase     = 0;
    logic        req_taken     = 1'b0;

    // clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idling percentages per phase
    function automatic int sender_gap_pct(int ph);
        case (ph)
            1:       return 72;
            3:       return 27;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(int ph);
        case (ph)
            2:       return 72;
            3:       return 27;
            default: return 0;
        endcase
    endfunction

    // applies one operation to the shadow table and returns its response
    function automatic result_t apply_record_op(logic [1:0] fn, logic [31:0] key,
                                                logic [31:0] qty, logic [31:0] price,
                                                logic [31:0] dlt);
        result_t r;
        int      slot;
        int      i;
        bit      hit;
        r    = '0;
        slot = 0;
        hit  = 1'b0;
        for (i = 0; i < shadow_fill; i++)
        begin
            if (!hit && shadow_key[i] == key)
            begin
                hit  = 1'b1;
                slot = i;
            end
        end
        if (fn == FN_INSERT)
        begin
            if (shadow_fill >= TABLE_DEPTH)
                r.status = ST_FULL;
            else if (hit)
                r.status = ST_DUPLICATE;
            else
            begin
                shadow_key[shadow_fill]   = key;
                shadow_qty[shadow_fill]   = qty;
                shadow_price[shadow_fill] = price;
                shadow_fill++;
                r.status = ST_OK;
            end
        end
        else if (!hit)
            r.status = ST_NOT_FOUND;
        else
        begin
            r.status    = ST_OK;
            r.old_qty   = shadow_qty[slot];
            r.old_price = shadow_price[slot];
            // sums wrap at 32 bits
            if (fn == FN_ADD_QTY)
                shadow_qty[slot] = shadow_qty[slot] + dlt;
            else if (fn == FN_ADD_PRICE)
                shadow_price[slot] = shadow_price[slot] + dlt * 32'd100;
        end
        return r;
    endfunction

    task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (error_count < 100)
            $display("[%0t] response %0d: %s got %h expected %h",
                     $time, ops_answered, field, got, want);
        error_count++;
    endtask

    // mixes edge values, small values and full-range values
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4, 5:    return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(logic [1:0] fn, logic [31:0] key, logic [31:0] qty,
                            logic [31:0] price, logic [31:0] dlt, int phase);
        table_op_t op;
        op.fn    = fn;
        op.key   = key;
        op.qty   = qty;
        op.price = price;
        op.dlt   = dlt;
        op.phase = phase;
        op_queue.push_back(op);
        ops_queued++;
        if (fn == FN_INSERT)
            inserted_keys.push_back(key);
    endtask

    // monitor: predict on request transfer, check on response transfer
    always @(posedge clk)
    begin : watch_ports
        result_t want;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                results_due.push_back(apply_record_op(req_ch.func, req_ch.part_key,
                                                      req_ch.new_quantity,
                                                      req_ch.new_price_cents,
                                                      req_ch.delta));
                ops_accepted++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (results_due.size() == 0)
                    flag_mismatch("unexpected response, status", 32'(rsp_ch.status),
                                  32'd0);
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_ch.status !== want.status)
                        flag_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                    if (rsp_ch.old_quantity !== want.old_qty)
                        flag_mismatch("old_quantity", rsp_ch.old_quantity, want.old_qty);
                    if (rsp_ch.old_price_cents !== want.old_price)
                        flag_mismatch("old_price_cents", rsp_ch.old_price_cents,
                                      want.old_price);
                    status_seen[want.status]++;
                end
                ops_answered++;
            end
        end
    end

    // driver: present queued operations, random sender gaps and receiver stalls
    always @(negedge clk)
    begin : drive_ports
        table_op_t next_op;
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                if (op_queue.size() > 0 &&
                    $urandom_range(99) >= sender_gap_pct(op_queue[0].phase))
                begin
                    next_op = op_queue.pop_front();
                    req_ch.valid           <= 1'b1;
                    req_ch.func            <= next_op.fn;
                    req_ch.part_key        <= next_op.key;
                    req_ch.new_quantity    <= next_op.qty;
                    req_ch.new_price_cents <= next_op.price;
                    req_ch.delta           <= next_op.dlt;
                    cur_phase              <= next_op.phase;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct(cur_phase));
        end
    end

    // stimulus, reset and end of run
    initial
    begin : stimulus
        int          i;
        int          roll;
        logic [1:0]  fn;
        logic [31:0] key;
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.func            = FN_INSERT;
        req_ch.part_key        = '0;
        req_ch.new_quantity    = '0;
        req_ch.new_price_cents = '0;
        req_ch.delta           = '0;
        rsp_ch.ready           = 1'b0;

        // lookups on an empty table
        queue_op(FN_SEARCH,    32'h0000_0000, 32'h0, 32'h0, 32'h0, 0);
        queue_op(FN_ADD_QTY,   32'h0000_0005, 32'h0, 32'h0, 32'h1, 0);
        queue_op(FN_ADD_PRICE, 32'h8000_0000, 32'h0, 32'h0, 32'h1, 0);
        // inserts with extreme keys and values
        queue_op(FN_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 0);
        queue_op(FN_INSERT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0);
        queue_op(FN_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0, 0);
        queue_op(FN_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 0);
        // duplicate key
        queue_op(FN_INSERT, 32'h0000_0000, 32'h1234_5678, 32'h9abc_def0, 32'h0, 0);
        queue_op(FN_INSERT, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 0);
        // searches and adds that wrap
        queue_op(FN_SEARCH,    32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h0, 0);
        queue_op(FN_ADD_QTY,   32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001, 0);
        queue_op(FN_SEARCH,    32'h8000_0000, 32'h0, 32'h0, 32'h0, 0);
        queue_op(FN_ADD_QTY,   32'h7fff_ffff, 32'h0, 32'h0, 32'h8000_0000, 0);
        queue_op(FN_ADD_PRICE, 32'h7fff_ffff, 32'h0, 32'h0, 32'h7fff_ffff, 0);
        queue_op(FN_ADD_PRICE, 32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000, 0);
        queue_op(FN_SEARCH,    32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 0);
        queue_op(FN_ADD_PRICE, 32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 0);
        queue_op(FN_SEARCH,    32'hffff_ffff, 32'h0, 32'h0, 32'h0, 0);
        queue_op(FN_ADD_QTY,   32'h0000_0000, 32'h0, 32'h0, 32'h0, 0);
        queue_op(FN_SEARCH,    32'h0000_0000, 32'h0, 32'h0, 32'h0, 0);
        // absent key in a non-empty table
        queue_op(FN_SEARCH,    32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
        queue_op(FN_ADD_QTY,   32'hffff_fffe, 32'h0, 32'h0, 32'h7fff_ffff, 0);

        // random operations; inserts fill the table about two thirds through
        for (i = 0; i < RANDOM_OPS; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 35)
                fn = FN_INSERT;
            else if (roll < 55)
                fn = FN_SEARCH;
            else if (roll < 78)
                fn = FN_ADD_QTY;
            else
                fn = FN_ADD_PRICE;
            // inserts mostly use fresh keys, lookups mostly stored ones
            if ($urandom_range(99) < ((fn == FN_INSERT) ? 30 : 80))
                key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
            else if ($urandom_range(3) == 0)
                key = pick_word();
            else
                key = $urandom;
            queue_op(fn, key, pick_word(), pick_word(), pick_word(), (i / PHASE_LEN) % 4);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every transfer to be answered, then watch for strays
        while (ops_accepted < ops_queued || results_due.size() != 0)
            @(negedge clk);
        repeat (TABLE_DEPTH + 20) @(negedge clk);

        $display("%0d operations answered, %0d records stored (capacity %0d)",
                 ops_answered, shadow_fill, TABLE_DEPTH);
        $display("status mix: ok %0d, not found %0d, duplicate %0d, full %0d",
                 status_seen[ST_OK], status_seen[ST_NOT_FOUND],
                 status_seen[ST_DUPLICATE], status_seen[ST_FULL]);
        if (error_count == 0 && results_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hard limit on run time
    initial
    begin : watchdog
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/krt_pkg.sv
rtl/core/krt_req_if.sv
rtl/core/krt_rsp_if.sv
rtl/core/krt_cell.sv
rtl/core/krt_chain.sv
rtl/core/keyed_record_table_unit.sv
tb/testbench.sv
